FILE: hw/rtl/mtb_pkg.sv
package mtb_pkg;

  localparam int unsigned TIMERS_DEF = 8;
  localparam int unsigned ID_W       = 3;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned MAX_RES    = 8;
  localparam int unsigned RES_CNT_W  = $clog2(MAX_RES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_TICK    = 3'd3,
    OP_QUERY   = 3'd4,
    OP_DESTROY = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_CREATED   = 2'd0,
    ST_STARTED   = 2'd1,
    ST_STOPPED   = 2'd2,
    ST_DESTROYED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_FLUSH
  } fsm_e;

  typedef enum logic {
    KIND_EXPIRY = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [TICK_W-1:0] countdown;
    logic [TICK_W-1:0] delay;
    logic [TICK_W-1:0] period;
    logic              hard;
    status_e           status;
  } entry_t;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   which_timer;
    status_e           status;
    logic [TICK_W-1:0] remaining;
    logic [TICK_W-1:0] info_delay;
    logic [TICK_W-1:0] info_period;
    logic              info_hard;
    logic              last;
  } result_t;

  localparam entry_t ENTRY_RST = '{
    countdown: '0,
    delay:     '0,
    period:    '0,
    hard:      1'b0,
    status:    ST_DESTROYED
  };

  // countdown load on init and start: delay, or period when the delay is zero
  function automatic logic [TICK_W-1:0] first_load(input logic [TICK_W-1:0] dly,
                                                    input logic [TICK_W-1:0] per);
    first_load = (dly != '0) ? dly : per;
  endfunction

endpackage

FILE: hw/rtl/mtb_if.sv
interface mtb_req_if import mtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ID_W-1:0]   timer_id;
  logic [TICK_W-1:0] start_delay;
  logic [TICK_W-1:0] period_ticks;
  logic              hard_class;

  modport source (output valid, op, timer_id, start_delay, period_ticks, hard_class,
                  input ready);
  modport sink (input valid, op, timer_id, start_delay, period_ticks, hard_class,
                output ready);
endinterface

interface mtb_rsp_if import mtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ID_W-1:0]   which_timer;
  logic [1:0]        timer_status;
  logic [TICK_W-1:0] remaining;
  logic [TICK_W-1:0] info_delay;
  logic [TICK_W-1:0] info_period;
  logic              info_hard;
  logic              last;

  modport source (output valid, kind, which_timer, timer_status, remaining, info_delay,
                  info_period, info_hard, last, input ready);
  modport sink (input valid, kind, which_timer, timer_status, remaining, info_delay,
                info_period, info_hard, last, output ready);
endinterface

FILE: hw/rtl/multi_timer_bank_core.sv
// init, start, stop, destroy go through accept, memory read and update;
// a query reply is registered in the update step once the output register is free, then taken when ready
// tick: two passes (hard, then soft), one read-modify-write of the single-port timer
// memory per entry; a pass stalls when an event must go out while the output is busy
// reset clears control state and the per-timer valid flags; an unwritten timer
// reads as destroyed with zero fields, so no clearing pass is needed
module multi_timer_bank_core import mtb_pkg::*; #(
  parameter int unsigned NUM_TIMERS = TIMERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtb_req_if.sink   req_i,
  mtb_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  fsm_e                 state_q, state_d;
  op_e                  op_q, op_d;
  logic [ID_W-1:0]      tid_q, tid_d;
  logic [TICK_W-1:0]    dly_q, dly_d;
  logic [TICK_W-1:0]    per_q, per_d;
  logic                 hard_q, hard_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 cls_q, cls_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pend_vld_q, pend_vld_d;
  result_t              pend_q, pend_d;
  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;
  logic [NUM_TIMERS-1:0] vld_q, vld_d;

  entry_t mem [NUM_TIMERS];
  entry_t rdata_q;
  logic   rd_en, we;
  entry_t wdata;

  logic [IDX_W+ID_W-1:0] tid_ext;
  logic [IDX_W+ID_W-1:0] idx_ext;
  logic [IDX_W-1:0]      addr;
  logic                  tid_ok;
  logic                  out_free;
  entry_t                ent;
  logic                  match, fires;
  logic [TICK_W-1:0]     cd_dec;
  result_t               ev;

  assign tid_ext  = {{IDX_W{1'b0}}, tid_q};
  assign idx_ext  = {{ID_W{1'b0}}, idx_q};
  assign tid_ok   = (int'(tid_q) < NUM_TIMERS);
  assign addr     = (op_q == OP_TICK) ? idx_q : tid_ext[IDX_W-1:0];
  assign out_free = !out_vld_q || rsp_o.ready;
  assign ent      = vld_q[addr] ? rdata_q : ENTRY_RST;

  // expiry evaluation for the entry under the scan
  assign match  = (ent.status == ST_STARTED) && (ent.hard == cls_q);
  assign cd_dec = ent.countdown - TICK_W'(1);
  assign fires  = match && ((ent.countdown == '0) || (cd_dec == '0));

  always_comb begin
    ev             = '0;
    ev.kind        = KIND_EXPIRY;
    ev.which_timer = idx_ext[ID_W-1:0];
    ev.status      = ST_STARTED;
    ev.remaining   = (ent.countdown == '0) ? '0 : cd_dec;
    if (fires) begin
      if (ent.period != '0) begin
        ev.remaining = ent.period;
      end else begin
        ev.status = ST_STOPPED;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    tid_d      = tid_q;
    dly_d      = dly_q;
    per_d      = per_q;
    hard_d     = hard_q;
    idx_d      = idx_q;
    cls_d      = cls_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    vld_d      = vld_q;
    rd_en      = 1'b0;
    we         = 1'b0;
    wdata      = ent;
    req_i.ready = 1'b0;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d   = op_e'(req_i.op);
          tid_d  = req_i.timer_id;
          dly_d  = req_i.start_delay;
          per_d  = req_i.period_ticks;
          hard_d = req_i.hard_class;
          idx_d  = '0;
          cls_d  = 1'b1;
          cnt_d  = '0;
          // unused opcodes are dropped here
          if (req_i.op <= OP_DESTROY) begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        case (op_q)
          OP_INIT: begin
            if (tid_ok) begin
              we          = 1'b1;
              wdata       = '{countdown: first_load(dly_q, per_q), delay: dly_q,
                              period: per_q, hard: hard_q, status: ST_CREATED};
              vld_d[addr] = 1'b1;
            end
            state_d = S_IDLE;
          end
          OP_START: begin
            if (tid_ok && (ent.status == ST_CREATED || ent.status == ST_STOPPED)) begin
              we              = 1'b1;
              wdata.countdown = first_load(ent.delay, ent.period);
              wdata.status    = ST_STARTED;
            end
            state_d = S_IDLE;
          end
          OP_STOP: begin
            if (tid_ok && ent.status == ST_STARTED) begin
              we           = 1'b1;
              wdata.status = ST_STOPPED;
            end
            state_d = S_IDLE;
          end
          OP_DESTROY: begin
            // an unwritten timer already reads as destroyed
            if (tid_ok && ent.status != ST_DESTROYED) begin
              we           = 1'b1;
              wdata.status = ST_DESTROYED;
            end
            state_d = S_IDLE;
          end
          OP_QUERY: begin
            if (out_free) begin
              out_vld_d         = 1'b1;
              out_d             = '0;
              out_d.kind        = KIND_QUERY;
              out_d.which_timer = tid_q;
              out_d.status      = ST_DESTROYED;
              out_d.last        = 1'b1;
              if (tid_ok) begin
                out_d.status      = ent.status;
                out_d.remaining   = ent.countdown;
                out_d.info_delay  = ent.delay;
                out_d.info_period = ent.period;
                out_d.info_hard   = ent.hard;
              end
              state_d = S_IDLE;
            end
          end
          OP_TICK: begin
            // an event waits in the holding register until the next one shows
            // whether it is the last
            if (!(fires && cnt_q < RES_CNT_W'(MAX_RES) && pend_vld_q && !out_free)) begin
              if (match) begin
                we              = 1'b1;
                wdata.countdown = ev.remaining;
                wdata.status    = ev.status;
              end
              if (fires && cnt_q < RES_CNT_W'(MAX_RES)) begin
                if (pend_vld_q) begin
                  out_vld_d = 1'b1;
                  out_d     = pend_q;
                end
                pend_vld_d = 1'b1;
                pend_d     = ev;
                cnt_d      = cnt_q + RES_CNT_W'(1);
              end
              if (idx_q == IDX_W'(NUM_TIMERS - 1)) begin
                idx_d = '0;
                if (cls_q) begin
                  cls_d   = 1'b0;
                  state_d = S_RD;
                end else begin
                  state_d = S_FLUSH;
                end
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_RD;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = pend_q;
          out_d.last = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_INIT;
      idx_q      <= '0;
      cls_q      <= 1'b1;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      vld_q      <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      idx_q      <= idx_d;
      cls_q      <= cls_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      vld_q      <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q  <= tid_d;
    dly_q  <= dly_d;
    per_q  <= per_d;
    hard_q <= hard_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // timer memory, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[addr];
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.kind         = out_q.kind;
  assign rsp_o.which_timer  = out_q.which_timer;
  assign rsp_o.timer_status = out_q.status;
  assign rsp_o.remaining    = out_q.remaining;
  assign rsp_o.info_delay   = out_q.info_delay;
  assign rsp_o.info_period  = out_q.info_period;
  assign rsp_o.info_hard    = out_q.info_hard;
  assign rsp_o.last         = out_q.last;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("held expiry event left behind after a tick");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(MAX_RES))
    else $error("expiry event count past the limit");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (op_q == OP_TICK))
    else $error("held expiry event outside a tick");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !we)
    else $error("timer memory read and written in one cycle");
`endif

endmodule
